/* sv/rmtp_pkg.sv */
`timescale 1ns / 1ps

package rmtp_pkg;

  // Table size used when the top level is not given one.
  localparam int MaxTasksDef = 16;

  // Configuration port.
  localparam int CfgDataW = 5;
  localparam int CfgIdxW  = 1;
  localparam logic [CfgIdxW-1:0] REG_TASK_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_IDLE_TASK  = 1'd1;

  // Operation codes of an input item.
  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_TICK     = 3'd1;
  localparam logic [2:0] OP_SET      = 3'd2;
  localparam logic [2:0] OP_WAKE_REQ = 3'd3;
  localparam logic [2:0] OP_WAIT_REQ = 3'd4;

  // Task state codes.
  localparam logic [1:0] ST_OTHER   = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_WAIT    = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  task_index;
    logic [15:0] period;
    logic [15:0] deadline;
    logic [1:0]  new_state;
    logic [15:0] wait_ticks;
    logic [3:0]  current_task;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [3:0] chosen_idx;
    logic       is_idle;
  } out_item_t;

  // Datapath steps issued by the controller.
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_CHG_RD,
    STEP_CHG_WR,
    STEP_SCAN,
    STEP_POST
  } step_e;

  typedef struct packed {
    logic  take;
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

/* sv/rmtp_dpath.sv */
`timescale 1ns / 1ps

module rmtp_dpath #(
  parameter int MAX_TASKS = rmtp_pkg::MaxTasksDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmtp_pkg::in_item_t                in_data_i,
  input  rmtp_pkg::cmd_t                    cmd_i,
  output rmtp_pkg::status_t                 status_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output rmtp_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [rmtp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rmtp_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CntW = $clog2(MAX_TASKS + 1);

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] deadline;
    logic [15:0] quantum;
    logic [31:0] release_t;
  } entry_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [15:0] timer;
  } sched_t;

  entry_t pd_mem [MAX_TASKS];
  sched_t st_mem [MAX_TASKS];

  entry_t              pd_rd_q;
  sched_t              st_rd_q;
  logic                stv_rd_q;
  logic [MAX_TASKS-1:0] st_vld_q, wake_q, wait_q;
  rmtp_pkg::in_item_t  item_q;
  logic [4:0]          task_count_q;
  logic [3:0]          idle_task_q;
  logic [CntW-1:0]     cnt_q;
  logic                ev_vld_q;
  logic [IdxW-1:0]     ev_idx_q;
  logic                found_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [15:0]         best_per_q;
  logic                out_vld_q;
  rmtp_pkg::out_item_t out_q;

  logic [IdxW-1:0] in_idx, cur_idx, rd_addr;
  logic            in_ok, chg_skip, issue, ev_is_idle;
  logic [CntW-1:0] lim;
  logic            do_load, do_set;
  entry_t          chg_entry;
  logic [15:0]     q_dec;
  logic            refill;
  sched_t          ev_in, ev_out;
  logic            wk_clr, cand, better;

  // Addressing of the table.
  assign in_idx   = IdxW'(in_data_i.task_index);
  assign in_ok    = 32'(in_data_i.task_index) < MAX_TASKS;
  assign cur_idx  = IdxW'(item_q.current_task);
  assign chg_skip = (item_q.current_task == idle_task_q) ||
                    (32'(item_q.current_task) >= MAX_TASKS);
  assign lim      = (32'(task_count_q) < MAX_TASKS) ? CntW'(task_count_q)
                                                    : CntW'(MAX_TASKS);
  assign issue    = (cmd_i.step == rmtp_pkg::STEP_SCAN) && (cnt_q < lim);
  assign rd_addr  = (cmd_i.step == rmtp_pkg::STEP_CHG_RD) ? cur_idx : cnt_q[IdxW-1:0];
  assign do_load  = cmd_i.take && (in_data_i.opcode == rmtp_pkg::OP_LOAD) && in_ok;
  assign do_set   = cmd_i.take && (in_data_i.opcode == rmtp_pkg::OP_SET) && in_ok;
  assign ev_is_idle = 32'(ev_idx_q) == 32'(idle_task_q);

  // Charging of the task that ran: one unit off, refill on empty or on request.
  always_comb begin
    chg_entry = pd_rd_q;
    q_dec     = pd_rd_q.quantum - 16'd1;
    refill    = (q_dec == 16'd0) || wait_q[cur_idx];
    if (refill) begin
      chg_entry.release_t = pd_rd_q.release_t + 32'(pd_rd_q.period);
      chg_entry.quantum   = pd_rd_q.deadline;
    end else begin
      chg_entry.quantum = q_dec;
    end
  end

  // Wake handling and candidate test for the entry read in the cycle before.
  always_comb begin
    ev_in  = stv_rd_q ? st_rd_q : '0;
    ev_out = ev_in;
    wk_clr = 1'b0;
    if (ev_out.state == rmtp_pkg::ST_WAIT && wake_q[ev_idx_q]) begin
      ev_out.state = rmtp_pkg::ST_READY;
      wk_clr = 1'b1;
    end
    if (ev_out.state == rmtp_pkg::ST_WAIT && ev_out.timer != 16'd0) begin
      ev_out.timer = ev_out.timer - 16'd1;
      if (ev_out.timer == 16'd0) begin
        ev_out.state = rmtp_pkg::ST_READY;
      end
    end
    cand = ev_vld_q && !ev_is_idle && (pd_rd_q.release_t <= item_q.now) &&
           (ev_out.state == rmtp_pkg::ST_READY || ev_out.state == rmtp_pkg::ST_RUNNING);
    better = cand && (!found_q || pd_rd_q.period < best_per_q);
  end

  // Table memories: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      pd_mem[in_idx] <= '{period: in_data_i.period, deadline: in_data_i.deadline,
                          quantum: in_data_i.deadline, release_t: 32'd1};
    end else if (cmd_i.step == rmtp_pkg::STEP_CHG_WR && !chg_skip) begin
      pd_mem[cur_idx] <= chg_entry;
    end
    if (do_set) begin
      st_mem[in_idx] <= '{state: in_data_i.new_state, timer: in_data_i.wait_ticks};
    end else if (ev_vld_q && !ev_is_idle) begin
      st_mem[ev_idx_q] <= ev_out;
    end
    pd_rd_q  <= pd_mem[rd_addr];
    st_rd_q  <= st_mem[rd_addr];
    stv_rd_q <= st_vld_q[rd_addr];
  end

  // Item register, scan progress and best candidate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q <= in_data_i;
    end
    if (cmd_i.step == rmtp_pkg::STEP_SCAN) begin
      ev_idx_q <= cnt_q[IdxW-1:0];
      if (better) begin
        best_idx_q <= ev_idx_q;
        best_per_q <= pd_rd_q.period;
      end
    end
    if (cmd_i.step == rmtp_pkg::STEP_POST) begin
      out_q.chosen_idx <= found_q ? 4'(best_idx_q) : idle_task_q;
      out_q.is_idle    <= !found_q;
    end
  end

  // Control state: flags, registers, counters and the result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q     <= '0;
      wake_q       <= '0;
      wait_q       <= '0;
      task_count_q <= '0;
      idle_task_q  <= '0;
      cnt_q        <= '0;
      ev_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rmtp_pkg::REG_TASK_COUNT) begin
          task_count_q <= cfg_wdata_i;
        end else if (cfg_idx_i == rmtp_pkg::REG_IDLE_TASK) begin
          idle_task_q <= cfg_wdata_i[3:0];
        end
      end
      if (do_set) begin
        st_vld_q[in_idx] <= 1'b1;
      end else if (ev_vld_q && !ev_is_idle) begin
        st_vld_q[ev_idx_q] <= 1'b1;
      end
      if (cmd_i.take && in_ok && in_data_i.opcode == rmtp_pkg::OP_WAKE_REQ) begin
        wake_q[in_idx] <= 1'b1;
      end else if (ev_vld_q && !ev_is_idle && wk_clr) begin
        wake_q[ev_idx_q] <= 1'b0;
      end
      if (cmd_i.take && in_ok && in_data_i.opcode == rmtp_pkg::OP_WAIT_REQ) begin
        wait_q[in_idx] <= 1'b1;
      end else if (cmd_i.step == rmtp_pkg::STEP_CHG_WR && !chg_skip && refill) begin
        wait_q[cur_idx] <= 1'b0;
      end
      case (cmd_i.step)
        rmtp_pkg::STEP_CHG_RD: begin
          cnt_q    <= '0;
          ev_vld_q <= 1'b0;
          found_q  <= 1'b0;
        end
        rmtp_pkg::STEP_SCAN: begin
          if (issue) begin
            cnt_q <= cnt_q + CntW'(1);
          end
          ev_vld_q <= issue;
          if (better) begin
            found_q <= 1'b1;
          end
        end
        default: begin
          ev_vld_q <= 1'b0;
        end
      endcase
      if (cmd_i.step == rmtp_pkg::STEP_POST) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign status_o.scan_done = (cnt_q >= lim) && !ev_vld_q;
  assign status_o.out_free  = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

/* sv/rmtp_ctrl.sv */
`timescale 1ns / 1ps

module rmtp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        in_opcode_i,
  output logic              in_stall_o,
  input  rmtp_pkg::status_t status_i,
  output rmtp_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHG_RD,
    S_CHG_WR,
    S_SCAN,
    S_POST
  } state_e;

  state_e state_q;
  logic   accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = state_q != S_IDLE;

  // Step decode for the datapath.
  always_comb begin
    cmd_o.take = accept;
    case (state_q)
      S_CHG_RD: cmd_o.step = rmtp_pkg::STEP_CHG_RD;
      S_CHG_WR: cmd_o.step = rmtp_pkg::STEP_CHG_WR;
      S_SCAN:   cmd_o.step = rmtp_pkg::STEP_SCAN;
      S_POST:   cmd_o.step = status_i.out_free ? rmtp_pkg::STEP_POST
                                               : rmtp_pkg::STEP_NONE;
      default:  cmd_o.step = rmtp_pkg::STEP_NONE;
    endcase
  end

  // A tick runs charge, table scan and result; other items finish on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && in_opcode_i == rmtp_pkg::OP_TICK) begin
            state_q <= S_CHG_RD;
          end
        end
        S_CHG_RD: state_q <= S_CHG_WR;
        S_CHG_WR: state_q <= S_SCAN;
        S_SCAN: begin
          if (status_i.scan_done) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/rate_monotonic_task_picker.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   rmtp_pkg::in_item_t
// out      output     out_valid_o / out_stall_i rmtp_pkg::out_item_t
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Load, set-state and request items finish on transfer and do not stall the input.
// A tick runs the charge read-modify-write, then scans L = min(task_count, MAX_TASKS)
// table entries, one per cycle through the read port, finishes the last read and
// compare, and registers the result once the output register is free.
// Reset clears the control state, the state valid bits and the flags; there is
// no clearing pass. A waiting result is held in the output register while the
// next item is taken.

module rate_monotonic_task_picker #(
  parameter int MAX_TASKS = rmtp_pkg::MaxTasksDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rmtp_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rmtp_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [rmtp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rmtp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  rmtp_pkg::cmd_t    cmd;
  rmtp_pkg::status_t status;

  rmtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rmtp_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // A tick transfer keeps the input stalled while its work runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.opcode == rmtp_pkg::OP_TICK) |=> in_stall_o)
    else $error("tick did not start its sequence");

  // Any other transfer completes at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.opcode != rmtp_pkg::OP_TICK) |=> !in_stall_o)
    else $error("non-tick item held the input");

  // The datapath steps only run while the input is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step != rmtp_pkg::STEP_NONE) |-> in_stall_o)
    else $error("datapath step outside a tick");

endmodule

/* test/rate_monotonic_task_picker_tb.sv */
`timescale 1ns / 1ps

module rate_monotonic_task_picker_tb;

  localparam int NumTasks = 16;
  localparam logic [2:0] OP_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST   = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rmtp_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rmtp_pkg::out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [rmtp_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rmtp_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  rate_monotonic_task_picker dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the task table and registers.
  logic [4:0]  sh_count;
  logic [3:0]  sh_idle;
  logic [15:0] sh_period [NumTasks];
  logic [15:0] sh_deadline [NumTasks];
  logic [15:0] sh_quantum [NumTasks];
  logic [31:0] sh_release [NumTasks];
  logic [1:0]  sh_state [NumTasks];
  logic [15:0] sh_timer [NumTasks];
  logic        sh_wake [NumTasks];
  logic        sh_wait [NumTasks];

  rmtp_pkg::out_item_t picks_due[$];
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;

  // Apply one accepted transfer to the shadow table; a tick queues its pick.
  task automatic track_item(input rmtp_pkg::in_item_t it);
    int lim;
    int best;
    bit found;
    int c;
    rmtp_pkg::out_item_t res;
    lim = (sh_count < NumTasks) ? sh_count : NumTasks;
    case (it.opcode)
      rmtp_pkg::OP_LOAD: begin
        sh_period[it.task_index] = it.period;
        sh_deadline[it.task_index] = it.deadline;
        sh_quantum[it.task_index] = it.deadline;
        sh_release[it.task_index] = 32'd1;
      end
      rmtp_pkg::OP_SET: begin
        sh_state[it.task_index] = it.new_state;
        sh_timer[it.task_index] = it.wait_ticks;
      end
      rmtp_pkg::OP_WAKE_REQ: sh_wake[it.task_index] = 1'b1;
      rmtp_pkg::OP_WAIT_REQ: sh_wait[it.task_index] = 1'b1;
      rmtp_pkg::OP_TICK: begin
        // Wake waiting tasks: the request first, then the timer.
        for (int i = 0; i < lim; i++) begin
          if (i == sh_idle) continue;
          if (sh_state[i] == rmtp_pkg::ST_WAIT && sh_wake[i]) begin
            sh_state[i] = rmtp_pkg::ST_READY;
            sh_wake[i] = 1'b0;
          end
          if (sh_state[i] == rmtp_pkg::ST_WAIT && sh_timer[i] != 0) begin
            sh_timer[i] = sh_timer[i] - 16'd1;
            if (sh_timer[i] == 0) sh_state[i] = rmtp_pkg::ST_READY;
          end
        end
        // Charge the task that ran.
        c = it.current_task;
        if (c != sh_idle) begin
          sh_quantum[c] = sh_quantum[c] - 16'd1;
          if (sh_quantum[c] == 0 || sh_wait[c]) begin
            sh_wait[c] = 1'b0;
            sh_release[c] = sh_release[c] + {16'd0, sh_period[c]};
            sh_quantum[c] = sh_deadline[c];
          end
        end
        // Shortest period among released ready or running tasks.
        found = 1'b0;
        best = 0;
        for (int i = 0; i < lim; i++) begin
          if (i == sh_idle) continue;
          if (sh_release[i] <= it.now &&
              (sh_state[i] == rmtp_pkg::ST_READY ||
               sh_state[i] == rmtp_pkg::ST_RUNNING)) begin
            if (!found || sh_period[i] < sh_period[best]) begin
              best = i;
              found = 1'b1;
            end
          end
        end
        res.chosen_idx = found ? best[3:0] : sh_idle;
        res.is_idle = !found;
        picks_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Send one transfer, in bursts with random gaps.
  task automatic send_item(input rmtp_pkg::in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    track_item(it);
    burst_left--;
  endtask

  // Stop sending and wait until every pick has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rmtp_pkg::CfgIdxW-1:0] idx, input logic [4:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rmtp_pkg::REG_TASK_COUNT) sh_count = val;
    else sh_idle = val[3:0];
  endtask

  function automatic rmtp_pkg::in_item_t mk(input logic [2:0] op, input logic [3:0] idx,
                                            input logic [15:0] per, input logic [15:0] dl,
                                            input logic [1:0] st, input logic [15:0] wt,
                                            input logic [3:0] cur, input logic [31:0] tnow);
    rmtp_pkg::in_item_t it;
    it.opcode = op;
    it.task_index = idx;
    it.period = per;
    it.deadline = dl;
    it.new_state = st;
    it.wait_ticks = wt;
    it.current_task = cur;
    it.now = tnow;
    return it;
  endfunction

  // Random transfer, weighted toward ticks and state changes.
  function automatic rmtp_pkg::in_item_t rand_item();
    rmtp_pkg::in_item_t it;
    int w;
    it = mk(rmtp_pkg::OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
            2'($urandom), 16'($urandom), 4'($urandom), $urandom);
    w = $urandom_range(0, 99);
    if (w < 45) it.opcode = rmtp_pkg::OP_TICK;
    else if (w < 65) it.opcode = rmtp_pkg::OP_SET;
    else if (w < 75) it.opcode = rmtp_pkg::OP_WAKE_REQ;
    else if (w < 85) it.opcode = rmtp_pkg::OP_WAIT_REQ;
    else if (w < 93) it.opcode = rmtp_pkg::OP_LOAD;
    else it.opcode = 3'($urandom_range(OP_UNUSED, OP_LAST));
    if ($urandom_range(0, 3) != 0) begin
      it.period = 16'($urandom_range(1, 40));
      it.deadline = 16'($urandom_range(1, 6));
      it.wait_ticks = 16'($urandom_range(0, 4));
      it.now = 32'($urandom_range(0, 300));
    end
    return it;
  endfunction

  // Receiver stall: none, random, or a fixed pattern, switching over time.
  always @(posedge clk_i) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 400 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= (stall_cyc % 7) < 3;
    endcase
  end

  // Compare each picked task with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (picks_due.size() == 0) begin
        $error("unexpected pick: chosen_idx %0d is_idle %0d",
               out_data_o.chosen_idx, out_data_o.is_idle);
        errors++;
      end else begin
        if (out_data_o.chosen_idx !== picks_due[0].chosen_idx) begin
          $error("chosen_idx: expected %0d, actual %0d",
                 picks_due[0].chosen_idx, out_data_o.chosen_idx);
          errors++;
        end
        if (out_data_o.is_idle !== picks_due[0].is_idle) begin
          $error("is_idle: expected %0d, actual %0d",
                 picks_due[0].is_idle, out_data_o.is_idle);
          errors++;
        end
        void'(picks_due.pop_front());
      end
    end
  end

  // Every entry is loaded before any tick, so the scan never sees an unwritten one.
  task automatic test_load_table();
    write_reg(rmtp_pkg::REG_TASK_COUNT, 5'd16);
    write_reg(rmtp_pkg::REG_IDLE_TASK, 5'd0);
    send_item(mk(rmtp_pkg::OP_LOAD, 4'd0, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_LOAD, 4'd1, 16'd1, 16'd1, '0, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_LOAD, 4'd2, 16'd1, 16'd0, '0, '0, '0, '0));
    for (int i = 3; i < NumTasks; i++)
      send_item(mk(rmtp_pkg::OP_LOAD, 4'(i), 16'($urandom_range(2, 50)),
                   16'($urandom_range(1, 5)), '0, '0, '0, '0));
  endtask

  task automatic test_directed();
    // Nothing released at time zero: the idle task wins.
    send_item(mk(rmtp_pkg::OP_SET, 4'd1, '0, '0, rmtp_pkg::ST_READY, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_TICK, '0, '0, '0, '0, '0, 4'd0, 32'd0));
    // Equal periods: the lower index wins; a zero quantum wraps and does not refill.
    send_item(mk(rmtp_pkg::OP_SET, 4'd2, '0, '0, rmtp_pkg::ST_RUNNING, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_TICK, '0, '0, '0, '0, '0, 4'd2, 32'hFFFF_FFFF));
    // Deadline one: the quantum runs out and the release moves on.
    send_item(mk(rmtp_pkg::OP_TICK, '0, '0, '0, '0, '0, 4'd1, 32'd1));
    // Wake request while waiting, and a wait timer that counts down.
    send_item(mk(rmtp_pkg::OP_SET, 4'd3, '0, '0, rmtp_pkg::ST_WAIT, 16'd0, '0, '0));
    send_item(mk(rmtp_pkg::OP_WAKE_REQ, 4'd3, '0, '0, '0, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_SET, 4'd4, '0, '0, rmtp_pkg::ST_WAIT, 16'd2, '0, '0));
    send_item(mk(rmtp_pkg::OP_TICK, '0, '0, '0, '0, '0, 4'd15, 32'd100));
    send_item(mk(rmtp_pkg::OP_TICK, '0, '0, '0, '0, '0, 4'd0, 32'd100));
    // Wake request while not waiting is kept; periodic-wait forces a refill.
    send_item(mk(rmtp_pkg::OP_WAKE_REQ, 4'd5, '0, '0, '0, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_WAIT_REQ, 4'd3, '0, '0, '0, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_SET, 4'd5, '0, '0, rmtp_pkg::ST_WAIT, 16'hFFFF, '0, '0));
    send_item(mk(rmtp_pkg::OP_TICK, '0, '0, '0, '0, '0, 4'd3, 32'hFFFF));
    send_item(mk(rmtp_pkg::OP_SET, 4'd15, 16'hFFFF, 16'hFFFF, rmtp_pkg::ST_OTHER,
                 16'hFFFF, 4'd15, 32'hFFFF_FFFF));
    send_item(mk(OP_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF, rmtp_pkg::ST_WAIT, 16'hFFFF, 4'hF,
                 32'hFFFF_FFFF));
    send_item(mk(OP_LAST, '0, '0, '0, '0, '0, '0, '0));
    send_item(mk(rmtp_pkg::OP_TICK, '0, '0, '0, '0, '0, 4'd1, 32'h8000_0000));
  endtask

  // Register extremes: no entries, one entry, a count past the table, idle at the top.
  task automatic test_config_sweep();
    logic [4:0] counts [5] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd9};
    logic [4:0] idles [5] = '{5'd0, 5'd0, 5'd15, 5'd7, 5'd3};
    for (int k = 0; k < 5; k++) begin
      write_reg(rmtp_pkg::REG_TASK_COUNT, counts[k]);
      write_reg(rmtp_pkg::REG_IDLE_TASK, idles[k]);
      for (int n = 0; n < 6; n++) send_item(rand_item());
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(rmtp_pkg::REG_TASK_COUNT, 5'($urandom_range(0, 31)));
      write_reg(rmtp_pkg::REG_IDLE_TASK, 5'($urandom_range(0, 15)));
      for (int n = 0; n < 110; n++) begin
        send_item(rand_item());
        // Hold off until the block has answered everything once per phase.
        if (n == 55) drain();
      end
    end
  endtask

  initial begin
    sh_count = '0;
    sh_idle = '0;
    for (int i = 0; i < NumTasks; i++) begin
      sh_state[i] = rmtp_pkg::ST_OTHER;
      sh_timer[i] = '0;
      sh_wake[i] = 1'b0;
      sh_wait[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_table();
    test_directed();
    test_config_sweep();
    test_random();
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
sv/rmtp_pkg.sv
sv/rmtp_dpath.sv
sv/rmtp_ctrl.sv
sv/rate_monotonic_task_picker.sv
test/rate_monotonic_task_picker_tb.sv
